[sv/sfd_pkg.sv]
// Package for the sync frame deframer with Fletcher-8 checksum.
// Holds result kind codes, register indexes and reset values.
// No dependencies.
package sfd_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_LENGTH  = 2'd2
  } cfg_idx_e;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'd147;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'd224;
  localparam logic [15:0] MAX_LENGTH_RST  = 16'd4096;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_BAD_CHECK = 3'd2,
    KIND_TOO_LONG  = 3'd3,
    KIND_BAD_SYNC  = 3'd4
  } kind_e;

endpackage

[sv/sfd_if.sv]
// Valid/ready channel interfaces of the frame deframer: received bytes in,
// result items out. Standalone; widths follow the field list.
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, rx_byte, input ready);
  modport sink   (input valid, rx_byte, output ready);
endinterface

interface sfd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [7:0]  data_byte;
  logic [7:0]  msg_id;
  logic [15:0] frame_length;
  logic [15:0] byte_index;
  logic [31:0] error_count;

  modport source (output valid, result_kind, data_byte, msg_id, frame_length,
                  byte_index, error_count, input ready);
  modport sink   (input valid, result_kind, data_byte, msg_id, frame_length,
                  byte_index, error_count, output ready);
endinterface

[sv/sync_frame_deframer_fletcher8_top.sv]
// Byte-serial frame deframer: sync pair, id, 16-bit length, payload, Fletcher-8 pair.
// Depends on sfd_pkg and the channel interfaces in sfd_if.sv.
//
// Usage:
//   in_if  carries one received byte per transfer (rx_byte).
//   out_if carries result items: one per payload byte, plus one verdict
//          (good, checksum mismatch, length too large, bad second sync)
//          that closes each frame begun by a first sync byte.
//   cfg_*  writes the sync values and the largest accepted length; write
//          only while no transfer is in flight.
// A result is registered and appears on out_if in the cycle after the byte
// transfer that causes it. Throughput: one byte per cycle while out_if takes
// results, set by the single state update that runs between the parser state
// and the output register. Bytes that cause no result (matching sync, id,
// length low, check A, an accepted length high) leave the output untouched.
// Stall: the output register holds its item; in_if.ready stays high while
// the output register is empty or is being emptied in the same cycle.
// Reset: the parser waits for a first sync byte, sums and the error count
// clear, registers take their default values, and the output is empty.
module sync_frame_deframer_fletcher8_top
  import sfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sfd_byte_if.sink              in_if,
  sfd_result_if.source          out_if
);

  typedef enum logic [2:0] {
    PH_SYNC1  = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_ID     = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_LEN_HI = 3'd4,
    PH_DATA   = 3'd5,
    PH_CK_A   = 3'd6,
    PH_CK_B   = 3'd7
  } phase_e;

  logic [7:0]  sync_first_q, sync_second_q;
  logic [15:0] max_length_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  frame_id_q, frame_id_d;
  logic [7:0]  length_low_q, length_low_d;
  logic [15:0] length_q, length_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  check_first_q, check_first_d;
  logic [31:0] errors_q, errors_d;

  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] idx_q, idx_d;
  logic [31:0] err_q;
  logic        emit;

  logic        in_fire;
  logic [7:0]  rx;
  logic [7:0]  acc_a, acc_b;
  logic [31:0] errors_inc;
  logic [15:0] len_new;
  logic [16:0] count_next;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;
  assign rx          = in_if.rx_byte;

  assign acc_a      = sum_a_q + rx;
  assign acc_b      = sum_b_q + acc_a;
  assign errors_inc = (errors_q == 32'hFFFF_FFFF) ? errors_q : errors_q + 32'd1;
  assign len_new    = {rx, length_low_q};
  assign count_next = {1'b0, count_q} + 17'd1;

  always_comb begin
    phase_d       = phase_q;
    frame_id_d    = frame_id_q;
    length_low_d  = length_low_q;
    length_d      = length_q;
    count_d       = count_q;
    sum_a_d       = sum_a_q;
    sum_b_d       = sum_b_q;
    check_first_d = check_first_q;
    errors_d      = errors_q;
    emit          = 1'b0;
    kind_d        = KIND_PAYLOAD;
    data_d        = 8'd0;
    id_d          = frame_id_q;
    len_d         = length_q;
    idx_d         = 16'd0;
    if (in_fire) begin
      case (phase_q)
        PH_SYNC1: begin
          count_d = 16'd0;
          if (rx == sync_first_q) phase_d = PH_SYNC2;
        end
        PH_SYNC2: begin
          // second sync wins when both sync values are equal
          if (rx == sync_second_q) begin
            phase_d = PH_ID;
          end else if (rx != sync_first_q) begin
            errors_d = errors_inc;
            phase_d  = PH_SYNC1;
            emit     = 1'b1;
            kind_d   = KIND_BAD_SYNC;
            id_d     = 8'd0;
            len_d    = 16'd0;
          end
        end
        PH_ID: begin
          frame_id_d = rx;
          sum_a_d    = rx;
          sum_b_d    = rx;
          phase_d    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_low_d = rx;
          sum_a_d      = acc_a;
          sum_b_d      = acc_b;
          phase_d      = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          sum_a_d  = acc_a;
          sum_b_d  = acc_b;
          length_d = len_new;
          count_d  = 16'd0;
          len_d    = len_new;
          if (len_new > max_length_q) begin
            errors_d = errors_inc;
            phase_d  = PH_SYNC1;
            emit     = 1'b1;
            kind_d   = KIND_TOO_LONG;
          end else if (len_new == 16'd0) begin
            phase_d = PH_CK_A;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          sum_a_d = acc_a;
          sum_b_d = acc_b;
          count_d = count_next[15:0];
          if (count_next >= {1'b0, length_q}) phase_d = PH_CK_A;
          emit    = 1'b1;
          kind_d  = KIND_PAYLOAD;
          data_d  = rx;
          idx_d   = count_q;
        end
        PH_CK_A: begin
          check_first_d = rx;
          phase_d       = PH_CK_B;
        end
        PH_CK_B: begin
          phase_d = PH_SYNC1;
          emit    = 1'b1;
          if (check_first_q == sum_a_q && rx == sum_b_q) begin
            kind_d = KIND_GOOD;
          end else begin
            errors_d = errors_inc;
            kind_d   = KIND_BAD_CHECK;
          end
        end
        default: phase_d = PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      max_length_q  <= MAX_LENGTH_RST;
      phase_q       <= PH_SYNC1;
      frame_id_q    <= 8'd0;
      length_low_q  <= 8'd0;
      length_q      <= 16'd0;
      count_q       <= 16'd0;
      sum_a_q       <= 8'd0;
      sum_b_q       <= 8'd0;
      check_first_q <= 8'd0;
      errors_q      <= 32'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i[7:0];
          CFG_SYNC_SECOND: sync_second_q <= cfg_data_i[7:0];
          CFG_MAX_LENGTH:  max_length_q  <= cfg_data_i;
          default:         ;
        endcase
      end
      phase_q       <= phase_d;
      frame_id_q    <= frame_id_d;
      length_low_q  <= length_low_d;
      length_q      <= length_d;
      count_q       <= count_d;
      sum_a_q       <= sum_a_d;
      sum_b_q       <= sum_b_d;
      check_first_q <= check_first_d;
      errors_q      <= errors_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload: load on each result, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      data_q <= data_d;
      id_q   <= id_d;
      len_q  <= len_d;
      idx_q  <= idx_d;
      err_q  <= errors_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.result_kind  = kind_q;
  assign out_if.data_byte    = data_q;
  assign out_if.msg_id       = id_q;
  assign out_if.frame_length = len_q;
  assign out_if.byte_index   = idx_q;
  assign out_if.error_count  = err_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_if.ready)
    else $error("input stalled while output register empty");

  a_errors_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    errors_q >= $past(errors_q))
    else $error("error count decreased");

  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_PAYLOAD) |-> (idx_q < len_q))
    else $error("payload index beyond frame length");

  a_verdict_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KIND_PAYLOAD) |-> (data_q == 8'd0 && idx_q == 16'd0))
    else $error("verdict carries payload data");

endmodule
